>>> hw/rtl/pess_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pess_pkg
// shared types and constants of the polygon edge span scanner
// ----------------------------------------------------------------------------
package pess_pkg;

  // request kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PLAIN = 2'd1;
  localparam logic [1:0] KIND_COLOR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // configuration register indexes
  localparam logic CFG_CLIP_TOP    = 1'b0;
  localparam logic CFG_CLIP_BOTTOM = 1'b1;

  localparam logic signed [15:0] SPAN_MAX = 16'sh7fff;
  localparam logic signed [15:0] SPAN_MIN = 16'sh8000;

  // divider operand and counter widths
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 12;
  localparam int DIV_CW = 5;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_SETUP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_MADD,
    S_CHK,
    S_ROW_RD,
    S_ROW_WR,
    S_RD_REQ,
    S_RD_DATA
  } state_t;

endpackage

>>> hw/rtl/pess_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pess_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pess_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pess_pkg::div_req_t                req,
  output logic                              busy,
  output logic                              done,
  output logic [pess_pkg::DIV_NW-1:0]       quotient
);

  localparam int NW = pess_pkg::DIV_NW;
  localparam int DW = pess_pkg::DIV_DW;
  localparam int CW = pess_pkg::DIV_CW;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  always_comb begin
    trial    = {rem_r[DW-1:0], num_r[NW-1]};
    diff     = {1'b0, trial} - {2'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/polygon_edge_span_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_edge_span_scanner
// walks polygon edges into a per-row span store with gouraud colour
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tuser kind, tdata edge or row
//  out_    | master    | out_tvalid/out_tready| tdata row bounds and colours
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data (clip rows)
//
//  after reset a clearing pass fills the store; no request is taken meanwhile
//  clear request: one row written per cycle
//  edge request: setup, four divisions in the shared divider (slope, then red,
//    green and blue steps), a multiply-add catch-up for each when the edge
//    starts above row zero, then a read, write and check per covered row
//  read request: held while the output register is still full
//  one request at a time; the output register lets a new request in meanwhile
// ----------------------------------------------------------------------------
module polygon_edge_span_scanner #(
  parameter int ROWS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // kind
  // x_a, y_a, x_b, y_b, colour_a, colour_b, row
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // span_left, span_right, left_red, left_green, left_blue,
  // right_red, right_green, right_blue
  output logic [175:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int AW = $clog2(ROWS);
  localparam int YW = 14;               // signed row arithmetic
  localparam int NW = pess_pkg::DIV_NW;

  pess_pkg::state_t state_r, state_nxt;

  // request fields
  logic [1:0]         kind_r;
  logic signed [11:0] xa_r, ya_r, xb_r, yb_r;
  logic [23:0]        ca_r, cb_r;
  logic [7:0]         row_r;

  logic [8:0] clip_top_r, clip_bottom_r;

  // walk state
  logic signed [YW-1:0] y_r, end_r;
  logic [11:0]          dy_r;
  logic signed [12:0]   dx_r;
  logic signed [8:0]    cd_r [3];
  logic [31:0]          pos_r, step_r;
  logic [23:0]          ch_r [3];
  logic [23:0]          chs_r [3];
  logic [31:0]          prod_r;
  logic [1:0]           idx_r;
  logic                 col_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 clr_col_r;

  // store
  logic [31:0] bnd_mem [ROWS];   // {left, right}
  logic [71:0] lcol_mem [ROWS];  // {red, green, blue}
  logic [71:0] rcol_mem [ROWS];
  logic [31:0] bnd_q_r;
  logic [71:0] lcol_q_r, rcol_q_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          bnd_we, lcol_we, rcol_we;
  logic [31:0]   bnd_wd;
  logic [71:0]   col_wd;

  logic         out_valid_r;
  logic [175:0] out_data_r;

  pess_pkg::div_req_t    div_req;
  logic                  div_busy, div_done;
  logic [NW-1:0]         div_quo;

  // setup arithmetic: order endpoints top to bottom and clip
  logic                 swap;
  logic signed [YW-1:0] y0e, y1e, end_e, end_c, cb_s, ct_s, rows_s;
  logic signed [11:0]   x0, x1;
  logic [23:0]          ctop, cbot;
  logic                 reject;

  always_comb begin
    swap   = ya_r > yb_r;
    x0     = swap ? xb_r : xa_r;
    x1     = swap ? xa_r : xb_r;
    y0e    = YW'(swap ? yb_r : ya_r);
    y1e    = YW'(swap ? ya_r : yb_r);
    ctop   = swap ? cb_r : ca_r;
    cbot   = swap ? ca_r : cb_r;
    cb_s   = $signed(YW'(clip_bottom_r));
    ct_s   = $signed(YW'(clip_top_r));
    rows_s = $signed(YW'(ROWS));
    end_e  = y1e + YW'(1);
    reject = (ya_r == yb_r) || !(y0e < cb_s && end_e >= ct_s);
    end_c  = end_e;
    if (end_c > cb_s)   end_c = cb_s;
    if (end_c > rows_s) end_c = rows_s;
  end

  // divider operand select: slope, then red, green, blue steps
  logic              num_neg;
  logic [NW-1:0]     num_mag;
  logic signed [8:0] cd_sel;
  logic [11:0]       dx_mag;
  logic [7:0]        cd_mag;

  always_comb begin
    cd_sel  = cd_r[idx_r - 2'd1];
    dx_mag  = dx_r[12] ? 12'(-dx_r) : dx_r[11:0];
    cd_mag  = cd_sel[8] ? 8'(-cd_sel) : cd_sel[7:0];
    num_neg = (idx_r == 2'd0) ? dx_r[12] : cd_sel[8];
    num_mag = (idx_r == 2'd0) ? {dx_mag, 16'h0} : NW'({cd_mag, 16'h0});
    div_req.start    = (state_r == pess_pkg::S_DIV_GO);
    div_req.dividend = num_mag;
    div_req.divisor  = dy_r;
  end

  pess_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic [31:0] quo_s;
  assign quo_s = num_neg ? -(32'(div_quo)) : 32'(div_quo);

  // shared multiplier for the start-above-row-zero catch-up
  logic [11:0] negy;
  logic [31:0] mul_op;
  assign negy   = 12'(-y_r);
  assign mul_op = (idx_r == 2'd0) ? step_r : {8'h0, chs_r[idx_r - 2'd1]};

  // row update compare
  logic signed [15:0] px, cur_left, cur_right;
  logic               upd_l, upd_r;
  assign px        = $signed(pos_r[31:16]);
  assign cur_left  = $signed(bnd_q_r[31:16]);
  assign cur_right = $signed(bnd_q_r[15:0]);
  assign upd_l     = px < cur_left;
  assign upd_r     = px > cur_right;

  logic out_free;
  logic in_acc;
  logic [YW-1:0] row_ext;
  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;
  assign row_ext  = YW'(row_r);

  // next state and memory port control
  always_comb begin
    state_nxt = state_r;
    rd_addr   = y_r[AW-1:0];
    wr_addr   = y_r[AW-1:0];
    bnd_we    = 1'b0;
    lcol_we   = 1'b0;
    rcol_we   = 1'b0;
    bnd_wd    = {upd_l ? px : cur_left, upd_r ? px : cur_right};
    col_wd    = {ch_r[0], ch_r[1], ch_r[2]};
    case (state_r)
      pess_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            pess_pkg::KIND_CLEAR: state_nxt = pess_pkg::S_CLR;
            pess_pkg::KIND_READ:  state_nxt = pess_pkg::S_RD_REQ;
            default:              state_nxt = pess_pkg::S_SETUP;
          endcase
        end
      end
      pess_pkg::S_CLR: begin
        wr_addr = clr_cnt_r;
        bnd_we  = 1'b1;
        bnd_wd  = {pess_pkg::SPAN_MAX, pess_pkg::SPAN_MIN};
        lcol_we = clr_col_r;
        rcol_we = clr_col_r;
        col_wd  = '0;
        if (clr_cnt_r == AW'(ROWS - 1)) state_nxt = pess_pkg::S_IDLE;
      end
      pess_pkg::S_SETUP:  state_nxt = reject ? pess_pkg::S_IDLE : pess_pkg::S_DIV_GO;
      pess_pkg::S_DIV_GO: state_nxt = pess_pkg::S_DIV_WAIT;
      pess_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (idx_r != 2'd3)   state_nxt = pess_pkg::S_DIV_GO;
          else if (y_r < 0)    state_nxt = pess_pkg::S_MUL;
          else                 state_nxt = pess_pkg::S_CHK;
        end
      end
      pess_pkg::S_MUL: state_nxt = pess_pkg::S_MADD;
      pess_pkg::S_MADD: state_nxt = (idx_r == 2'd3) ? pess_pkg::S_CHK : pess_pkg::S_MUL;
      pess_pkg::S_CHK: state_nxt = (y_r < end_r) ? pess_pkg::S_ROW_RD : pess_pkg::S_IDLE;
      pess_pkg::S_ROW_RD: state_nxt = pess_pkg::S_ROW_WR;
      pess_pkg::S_ROW_WR: begin
        bnd_we    = 1'b1;
        lcol_we   = col_r && upd_l;
        rcol_we   = col_r && upd_r;
        state_nxt = pess_pkg::S_CHK;
      end
      pess_pkg::S_RD_REQ: begin
        rd_addr   = row_ext[AW-1:0];
        state_nxt = pess_pkg::S_RD_DATA;
      end
      pess_pkg::S_RD_DATA: begin
        rd_addr = row_ext[AW-1:0];
        if (out_free) state_nxt = pess_pkg::S_IDLE;
      end
      default: state_nxt = pess_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pess_pkg::S_CLR;
    else        state_r <= state_nxt;
  end

  // span store
  always_ff @(posedge clk) begin
    if (bnd_we)  bnd_mem[wr_addr]  <= bnd_wd;
    if (lcol_we) lcol_mem[wr_addr] <= col_wd;
    if (rcol_we) rcol_mem[wr_addr] <= col_wd;
    bnd_q_r  <= bnd_mem[rd_addr];
    lcol_q_r <= lcol_mem[rd_addr];
    rcol_q_r <= rcol_mem[rd_addr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_top_r    <= 9'd0;
      clip_bottom_r <= 9'd240;
    end else if (cfg_valid) begin
      if (cfg_index == pess_pkg::CFG_CLIP_TOP) clip_top_r    <= cfg_data;
      else                                     clip_bottom_r <= cfg_data;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      clr_col_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == pess_pkg::S_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (in_acc) begin
        clr_cnt_r <= '0;
        clr_col_r <= 1'b0;
      end
      if (out_tready) out_valid_r <= 1'b0;
      if (state_r == pess_pkg::S_RD_DATA && out_free) out_valid_r <= 1'b1;
    end
  end

  // request capture and walk datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_tuser;
      xa_r   <= $signed(in_tdata[11:0]);
      ya_r   <= $signed(in_tdata[23:12]);
      xb_r   <= $signed(in_tdata[35:24]);
      yb_r   <= $signed(in_tdata[47:36]);
      ca_r   <= in_tdata[71:48];
      cb_r   <= in_tdata[95:72];
      row_r  <= in_tdata[103:96];
    end
    case (state_r)
      pess_pkg::S_SETUP: begin
        col_r  <= (kind_r == pess_pkg::KIND_COLOR);
        y_r    <= y0e;
        end_r  <= end_c;
        dy_r   <= 12'(y1e - y0e);
        dx_r   <= 13'(x1) - 13'(x0);
        pos_r  <= {{4{x0[11]}}, x0, 16'h0};
        idx_r  <= 2'd0;
        for (int k = 0; k < 3; k++) begin
          ch_r[k] <= {ctop[23-8*k -: 8], 16'h0};
          cd_r[k] <= $signed({1'b0, cbot[23-8*k -: 8]}) - $signed({1'b0, ctop[23-8*k -: 8]});
        end
      end
      pess_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (idx_r == 2'd0) step_r <= quo_s;
          else               chs_r[idx_r - 2'd1] <= quo_s[23:0];
          idx_r <= idx_r + 2'd1;
        end
      end
      pess_pkg::S_MUL: prod_r <= 32'(negy * mul_op);
      pess_pkg::S_MADD: begin
        if (idx_r == 2'd0) pos_r <= pos_r + prod_r;
        else               ch_r[idx_r - 2'd1] <= ch_r[idx_r - 2'd1] + prod_r[23:0];
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd3) y_r <= '0;
      end
      pess_pkg::S_ROW_WR: begin
        pos_r <= pos_r + step_r;
        for (int k = 0; k < 3; k++) ch_r[k] <= ch_r[k] + chs_r[k];
        y_r <= y_r + YW'(1);
      end
      pess_pkg::S_RD_DATA: begin
        if (out_free) begin
          if (row_ext >= YW'(ROWS))
            out_data_r <= {144'h0, pess_pkg::SPAN_MIN, pess_pkg::SPAN_MAX};
          else
            out_data_r <= {rcol_q_r[23:0], rcol_q_r[47:24], rcol_q_r[71:48],
                           lcol_q_r[23:0], lcol_q_r[47:24], lcol_q_r[71:48],
                           bnd_q_r[15:0], bnd_q_r[31:16]};
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == pess_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_we |-> (state_r == pess_pkg::S_CLR || state_r == pess_pkg::S_ROW_WR))
    else $error("store written outside clear or row update");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pess_pkg::S_ROW_WR) |-> (y_r >= 0 && y_r < end_r))
    else $error("row update outside the clipped range");

  a_div_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("divider busy while taking a request");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == pess_pkg::S_DIV_WAIT))
    else $error("quotient arrived with nobody waiting");

  a_color_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (lcol_we && state_r == pess_pkg::S_ROW_WR) |-> kind_r == pess_pkg::KIND_COLOR)
    else $error("colour written by a plain edge");

endmodule

>>> verif/polygon_edge_span_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_edge_span_scanner_test
// self-checking bench: edges and clears are walked into a local span store,
// row reads are predicted from it and compared field by field with the block
// ----------------------------------------------------------------------------
module polygon_edge_span_scanner_test;

  localparam int ROWS = 256;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 2000;

  // packed from the top down so that x_a lands in the lowest tdata bits
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         row;
    logic [23:0]        colour_b;
    logic [23:0]        colour_a;
    logic signed [11:0] y_b;
    logic signed [11:0] x_b;
    logic signed [11:0] y_a;
    logic signed [11:0] x_a;
  } edge_req_t;

  // span_left in the lowest tdata bits
  typedef struct packed {
    logic [23:0]        right_blue;
    logic [23:0]        right_green;
    logic [23:0]        right_red;
    logic [23:0]        left_blue;
    logic [23:0]        left_green;
    logic [23:0]        left_red;
    logic signed [15:0] span_right;
    logic signed [15:0] span_left;
  } row_span_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [8:0]   cfg_data = '0;

  always #2 clk = ~clk;

  polygon_edge_span_scanner #(.ROWS(ROWS)) DUT (.*);

  // local copy of the span store and the clip registers
  int          m_clip_top;
  int          m_clip_bottom;
  int          m_left [ROWS];
  int          m_right [ROWS];
  logic [23:0] m_lcol [ROWS][3];
  logic [23:0] m_rcol [ROWS][3];

  edge_req_t   pending_reqs[$];
  row_span_t   expected_spans[$];

  int  error_count = 0;
  int  reads_seen = 0;
  int  edges_sent = 0;
  int  sent_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  bit  send_hold = 1'b0;

  function automatic longint floor16(longint p);
    if (p >= 0) return p / 65536;
    return -((-p + 65535) / 65536);
  endfunction

  // edge walk on the local store; bounds widen, colours follow the bound
  function automatic void walk_edge(edge_req_t r);
    longint x0, y0, x1, y1, stop_row, dy, pos, step, y, px;
    longint ch[3], chs[3], a, b;
    logic [23:0] ctop, cbot;
    if (r.y_a == r.y_b) return;
    if (r.y_a > r.y_b) begin
      x0 = r.x_b; y0 = r.y_b; x1 = r.x_a; y1 = r.y_a;
      ctop = r.colour_b; cbot = r.colour_a;
    end else begin
      x0 = r.x_a; y0 = r.y_a; x1 = r.x_b; y1 = r.y_b;
      ctop = r.colour_a; cbot = r.colour_b;
    end
    stop_row = y1 + 1;
    if (!(y0 < m_clip_bottom && stop_row >= m_clip_top)) return;
    if (stop_row > m_clip_bottom) stop_row = m_clip_bottom;
    if (stop_row > ROWS) stop_row = ROWS;
    dy = y1 - y0;
    pos = x0 * 65536;
    step = ((x1 - x0) * 65536) / dy;
    for (int k = 0; k < 3; k++) begin
      a = longint'((ctop >> (16 - 8 * k)) & 8'hff) * 65536;
      b = longint'((cbot >> (16 - 8 * k)) & 8'hff) * 65536;
      ch[k] = a;
      chs[k] = (b - a) / dy;
    end
    y = y0;
    if (y < 0) begin
      pos -= y * step;
      for (int k = 0; k < 3; k++) ch[k] -= y * chs[k];
      y = 0;
    end
    for (; y < stop_row; y++) begin
      px = floor16(pos);
      if (px < m_left[y]) begin
        m_left[y] = int'(px);
        if (r.kind == pess_pkg::KIND_COLOR)
          for (int k = 0; k < 3; k++) m_lcol[y][k] = ch[k][23:0];
      end
      if (px > m_right[y]) begin
        m_right[y] = int'(px);
        if (r.kind == pess_pkg::KIND_COLOR)
          for (int k = 0; k < 3; k++) m_rcol[y][k] = ch[k][23:0];
      end
      pos += step;
      for (int k = 0; k < 3; k++) ch[k] += chs[k];
    end
  endfunction

  // applies one accepted request; a read queues its expected span
  function automatic void predict_span(edge_req_t r);
    row_span_t s;
    case (r.kind)
      pess_pkg::KIND_CLEAR: begin
        for (int i = 0; i < ROWS; i++) begin
          m_left[i] = pess_pkg::SPAN_MAX;
          m_right[i] = pess_pkg::SPAN_MIN;
        end
      end
      pess_pkg::KIND_PLAIN, pess_pkg::KIND_COLOR: walk_edge(r);
      default: begin
        s.span_left   = m_left[r.row][15:0];
        s.span_right  = m_right[r.row][15:0];
        s.left_red    = m_lcol[r.row][0];
        s.left_green  = m_lcol[r.row][1];
        s.left_blue   = m_lcol[r.row][2];
        s.right_red   = m_rcol[r.row][0];
        s.right_green = m_rcol[r.row][1];
        s.right_blue  = m_rcol[r.row][2];
        expected_spans.push_back(s);
      end
    endcase
  endfunction

  // driver: offers the oldest pending request, idles at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_span(pending_reqs.pop_front());
        sent_count++;
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_reqs.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].kind;
          in_tdata  <= pending_reqs[0][103:0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest expected span
  always @(posedge clk) begin
    row_span_t got, exp_s;
    if (rst_n) begin
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        reads_seen++;
        if (expected_spans.size() == 0) begin
          $error("result with no expected span");
          error_count++;
        end else begin
          exp_s = expected_spans.pop_front();
          if (got.span_left !== exp_s.span_left) begin
            $error("span_left exp %0d got %0d", exp_s.span_left, got.span_left);
            error_count++;
          end
          if (got.span_right !== exp_s.span_right) begin
            $error("span_right exp %0d got %0d", exp_s.span_right, got.span_right);
            error_count++;
          end
          if (got.left_red !== exp_s.left_red) begin
            $error("left_red exp %h got %h", exp_s.left_red, got.left_red);
            error_count++;
          end
          if (got.left_green !== exp_s.left_green) begin
            $error("left_green exp %h got %h", exp_s.left_green, got.left_green);
            error_count++;
          end
          if (got.left_blue !== exp_s.left_blue) begin
            $error("left_blue exp %h got %h", exp_s.left_blue, got.left_blue);
            error_count++;
          end
          if (got.right_red !== exp_s.right_red) begin
            $error("right_red exp %h got %h", exp_s.right_red, got.right_red);
            error_count++;
          end
          if (got.right_green !== exp_s.right_green) begin
            $error("right_green exp %h got %h", exp_s.right_green, got.right_green);
            error_count++;
          end
          if (got.right_blue !== exp_s.right_blue) begin
            $error("right_blue exp %h got %h", exp_s.right_blue, got.right_blue);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d spans outstanding", expected_spans.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic edge_req_t make_req(logic [1:0] k, int xa, int ya, int xb,
                                         int yb, logic [23:0] ca, logic [23:0] cb,
                                         int r);
    edge_req_t q;
    q.kind = k; q.x_a = 12'(xa); q.y_a = 12'(ya); q.x_b = 12'(xb); q.y_b = 12'(yb);
    q.colour_a = ca; q.colour_b = cb; q.row = 8'(r);
    return q;
  endfunction

  function automatic edge_req_t read_req(int r);
    return make_req(pess_pkg::KIND_READ, $urandom, $urandom, $urandom, $urandom,
                    24'($urandom), 24'($urandom), r);
  endfunction

  // random request; reads, rare clears and edges, the edges mostly short ones near the screen, some wide-ranging noise
  function automatic edge_req_t rand_req();
    edge_req_t q;
    int sel, y0;
    q = 106'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 2) q.kind = pess_pkg::KIND_CLEAR;
    else if (sel < 40) q.kind = pess_pkg::KIND_READ;
    else begin
      q.kind = (sel < 70) ? pess_pkg::KIND_COLOR : pess_pkg::KIND_PLAIN;
      if ($urandom_range(9) < 8) begin
        y0 = int'($urandom_range(300)) - 30;
        q.y_a = 12'(y0);
        q.y_b = 12'(y0 + int'($urandom_range(24)) - 12);
        q.x_a = 12'(int'($urandom_range(800)) - 400);
        q.x_b = 12'(int'($urandom_range(800)) - 400);
      end
    end
    return q;
  endfunction

  task automatic write_cfg(logic idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pess_pkg::CFG_CLIP_TOP) m_clip_top = val; else m_clip_bottom = val;
  endtask

  // waits for the queue to empty, every span to arrive and the walk to finish
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_spans.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      pending_reqs.push_back(rand_req());
      edges_sent++;
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    m_clip_top = 0;
    m_clip_bottom = 240;
    for (int i = 0; i < ROWS; i++) begin
      m_left[i] = pess_pkg::SPAN_MAX;
      m_right[i] = pess_pkg::SPAN_MIN;
      for (int k = 0; k < 3; k++) begin
        m_lcol[i][k] = '0;
        m_rcol[i][k] = '0;
      end
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (ROWS + 20) @(posedge clk);

    // directed: reads of untouched rows, extremes, horizontal and clipped edges
    pending_reqs.push_back(read_req(0));
    pending_reqs.push_back(read_req(255));
    pending_reqs.push_back(make_req(pess_pkg::KIND_COLOR, 10, 0, 50, 20,
                                    24'hff0000, 24'h00ff00, 0));
    pending_reqs.push_back(make_req(pess_pkg::KIND_COLOR, 90, 20, 5, 0,
                                    24'h0000ff, 24'hffffff, 0));
    pending_reqs.push_back(make_req(pess_pkg::KIND_PLAIN, -2048, -2048, 2047, 2047,
                                    0, 0, 0));
    pending_reqs.push_back(make_req(pess_pkg::KIND_PLAIN, 3, 7, 900, 7, 0, 0, 0));
    pending_reqs.push_back(make_req(pess_pkg::KIND_COLOR, 2047, 239, -2048, 300,
                                    24'hffffff, 24'h000000, 0));
    pending_reqs.push_back(make_req(pess_pkg::KIND_COLOR, -7, -100, 13, 2,
                                    24'h123456, 24'hfedcba, 0));
    pending_reqs.push_back(read_req(0));
    pending_reqs.push_back(read_req(1));
    pending_reqs.push_back(read_req(7));
    pending_reqs.push_back(read_req(20));
    pending_reqs.push_back(read_req(239));
    pending_reqs.push_back(read_req(240));
    pending_reqs.push_back(make_req(pess_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(read_req(0));
    pending_reqs.push_back(read_req(20));
    drain();

    // full store with clip rows at their extremes
    write_cfg(pess_pkg::CFG_CLIP_TOP, 0);
    write_cfg(pess_pkg::CFG_CLIP_BOTTOM, 256);
    pending_reqs.push_back(make_req(pess_pkg::KIND_COLOR, -2048, 2047, 2047, -2048,
                                    24'h00ff00, 24'hff00ff, 0));
    pending_reqs.push_back(read_req(255));
    pending_reqs.push_back(read_req(0));
    drain();

    random_phase(300, 0, 0);
    write_cfg(pess_pkg::CFG_CLIP_TOP, 256);
    write_cfg(pess_pkg::CFG_CLIP_BOTTOM, 0);
    random_phase(100, 77, 0);
    write_cfg(pess_pkg::CFG_CLIP_TOP, 40);
    write_cfg(pess_pkg::CFG_CLIP_BOTTOM, 200);
    random_phase(300, 77, 0);
    write_cfg(pess_pkg::CFG_CLIP_TOP, 0);
    write_cfg(pess_pkg::CFG_CLIP_BOTTOM, 240);
    random_phase(300, 0, 77);

    // receiver holds off while reads keep coming, so the input stalls
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b1;
    for (int i = 0; i < 12; i++) pending_reqs.push_back(read_req($urandom_range(255)));
    repeat (3000) @(posedge clk);
    recv_hold = 1'b0;
    drain();

    // sender pauses with reads still queued until every span has come
    for (int i = 0; i < 20; i++) pending_reqs.push_back(read_req($urandom_range(255)));
    repeat (10) @(posedge clk);
    send_hold = 1'b1;
    while (in_tvalid || expected_spans.size() != 0) @(posedge clk);
    send_hold = 1'b0;
    drain();

    write_cfg(pess_pkg::CFG_CLIP_TOP, 100);
    write_cfg(pess_pkg::CFG_CLIP_BOTTOM, 256);
    random_phase(400, 22, 22);

    $display("sent %0d requests, %0d random, checked %0d row reads",
             sent_count, edges_sent, reads_seen);
    $display("clip settings from empty window to full store, all idle patterns");
    if (error_count == 0 && expected_spans.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pess_pkg.sv
hw/rtl/pess_divider.sv
hw/rtl/polygon_edge_span_scanner.sv
verif/polygon_edge_span_scanner_test.sv
